FILE: hdl/bhi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhi_pkg
// Widths, limits and beat types shared by the height interpolation pipeline.
// ----------------------------------------------------------------------------
package bhi_pkg;

  // coordinate word and derived datapath widths
  localparam int COORD_BITS = 32;
  localparam int N_FIELDS   = 11;
  localparam int DIFF_W     = COORD_BITS + 1;        // vertex difference
  localparam int PROD_W     = 2 * DIFF_W;            // difference product
  localparam int SUM_W      = PROD_W + 1;            // det, n1, n2
  localparam int DY_W       = COORD_BITS;            // height difference magnitude
  localparam int LO_W       = (SUM_W + 1) / 2;       // low split of n magnitude
  localparam int HI_W       = SUM_W - LO_W;          // high split of n magnitude
  localparam int PART_W     = SUM_W + DY_W;          // |n| * |dy|
  localparam int NUM_W      = PART_W + 2;            // signed numerator
  localparam int QB         = COORD_BITS + 3;        // quotient bits developed

  // stream widths, padded to whole bytes
  localparam int IN_W  = ((N_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((COORD_BITS + 7) / 8) * 8;

  // result limits
  localparam logic signed [COORD_BITS-1:0] H_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] H_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam logic [QB-1:0] QUO_LIMIT = QB'({1'b1, {(COORD_BITS + 1){1'b0}}});

  // front end to numerator section
  typedef struct packed {
    logic [SUM_W-1:0]             det_mag;
    logic                         det_neg;
    logic                         det_zero;
    logic [SUM_W-1:0]             n1_mag;
    logic                         n1_neg;
    logic [SUM_W-1:0]             n2_mag;
    logic                         n2_neg;
    logic [DY_W-1:0]              dy1_mag;
    logic                         dy1_neg;
    logic [DY_W-1:0]              dy2_mag;
    logic                         dy2_neg;
    logic signed [COORD_BITS-1:0] v3_y;
  } front_t;

  // one divider step
  typedef struct packed {
    logic [SUM_W-1:0]             rem;
    logic [QB-1:0]                low;
    logic [QB-1:0]                quo;
    logic [SUM_W-1:0]             dmag;
    logic                         neg;
    logic                         ovf;
    logic                         degen;
    logic signed [COORD_BITS-1:0] v3_y;
  } div_t;

  // result beat
  typedef struct packed {
    logic signed [COORD_BITS-1:0] height;
    logic                         degenerate;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/barycentric_height_interp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_height_interp_core
// Height of a query point over the x-z projection of a triangle.
// ----------------------------------------------------------------------------
// Input stream s_axis: one beat holds the three vertices and the query point,
// all signed Q16.16. Output stream m_axis: one beat per input beat with the
// interpolated height (saturated) in tdata and the degenerate flag in tuser;
// a degenerate triangle gives height zero with the flag set.
// Throughput is one beat per cycle while the output queue has room. From the
// accepting edge to m_axis_tvalid a beat passes 4 front stages (differences,
// products, sums, magnitudes), 6 numerator stages, 35 divider stages (one
// quotient bit each, the longest part), one saturation stage and the output
// queue register.
// A two-entry output queue parts the sides: s_axis_tready drops only when
// both entries hold results the receiver has not taken; the whole pipeline
// then holds, nothing is lost or repeated, and tready returns the cycle after
// the receiver takes a beat. Synchronous reset empties the pipeline and the
// queue; no results are pending after it.
// ----------------------------------------------------------------------------
module barycentric_height_interp_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, query_x, query_z
  input  logic [bhi_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // height
  output logic [bhi_pkg::OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]                m_axis_tuser
);
  import bhi_pkg::*;

  logic   en;
  logic   front_valid, numer_valid, div_valid;
  front_t front_out;
  div_t   numer_out, div_out;
  res_t   res;

  assign s_axis_tready = en;

  bhi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (front_valid),
    .out_data  (front_out)
  );

  bhi_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_out),
    .out_valid (numer_valid),
    .out_data  (numer_out)
  );

  bhi_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (numer_valid),
    .in_data   (numer_out),
    .out_valid (div_valid),
    .out_data  (div_out)
  );

  bhi_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_data  (div_out),
    .en       (en),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (res)
  );

  assign m_axis_tdata = OUT_W'($unsigned(res.height));
  assign m_axis_tuser = res.degenerate;

`ifndef SYNTH
  // a degenerate result always carries height zero
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("degenerate beat with nonzero height");

  // input stalls only while results wait at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // a stalled divider output holds its beat
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (!s_axis_tready && div_valid) |=> (div_valid && $stable(div_out)))
    else $error("divider beat changed during stall");

  // reset leaves no pending result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");
`endif

endmodule
`default_nettype wire

FILE: hdl/bhi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhi_front
// Four stages: vertex differences, products, det/n1/n2 sums, magnitudes.
// ----------------------------------------------------------------------------
module bhi_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [bhi_pkg::IN_W-1:0] in_data,
  output logic                     out_valid,
  output bhi_pkg::front_t          out_data
);
  import bhi_pkg::*;

  // field positions in the input beat
  localparam int F_V1_X = 0;
  localparam int F_V1_Y = 1;
  localparam int F_V1_Z = 2;
  localparam int F_V2_X = 3;
  localparam int F_V2_Y = 4;
  localparam int F_V2_Z = 5;
  localparam int F_V3_X = 6;
  localparam int F_V3_Y = 7;
  localparam int F_V3_Z = 8;
  localparam int F_Q_X  = 9;
  localparam int F_Q_Z  = 10;
  localparam int STAGES = 4;

  logic signed [COORD_BITS-1:0] fld [N_FIELDS];
  logic [STAGES-1:0]            vld;

  logic signed [DIFF_W-1:0] s1_d, s1_e, s1_f, s1_g, s1_dx, s1_dz, s1_dy1, s1_dy2;
  logic signed [COORD_BITS-1:0] s1_v3y, s2_v3y, s3_v3y;
  logic signed [PROD_W-1:0] s2_pdg, s2_pef, s2_pddx, s2_pedz, s2_pfdx, s2_pgdz;
  logic [DY_W-1:0] s2_dy1_mag, s2_dy2_mag, s3_dy1_mag, s3_dy2_mag;
  logic s2_dy1_neg, s2_dy2_neg, s3_dy1_neg, s3_dy2_neg;
  logic signed [SUM_W-1:0] s3_det, s3_n1, s3_n2;

  // unpack fields
  always_comb begin
    for (int i = 0; i < N_FIELDS; i++) begin
      fld[i] = in_data[i*COORD_BITS +: COORD_BITS];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // differences, products, sums, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d   <= DIFF_W'(fld[F_V2_Z]) - DIFF_W'(fld[F_V3_Z]);
      s1_e   <= DIFF_W'(fld[F_V3_X]) - DIFF_W'(fld[F_V2_X]);
      s1_f   <= DIFF_W'(fld[F_V3_Z]) - DIFF_W'(fld[F_V1_Z]);
      s1_g   <= DIFF_W'(fld[F_V1_X]) - DIFF_W'(fld[F_V3_X]);
      s1_dx  <= DIFF_W'(fld[F_Q_X])  - DIFF_W'(fld[F_V3_X]);
      s1_dz  <= DIFF_W'(fld[F_Q_Z])  - DIFF_W'(fld[F_V3_Z]);
      s1_dy1 <= DIFF_W'(fld[F_V1_Y]) - DIFF_W'(fld[F_V3_Y]);
      s1_dy2 <= DIFF_W'(fld[F_V2_Y]) - DIFF_W'(fld[F_V3_Y]);
      s1_v3y <= fld[F_V3_Y];

      s2_pdg  <= s1_d * s1_g;
      s2_pef  <= s1_e * s1_f;
      s2_pddx <= s1_d * s1_dx;
      s2_pedz <= s1_e * s1_dz;
      s2_pfdx <= s1_f * s1_dx;
      s2_pgdz <= s1_g * s1_dz;
      s2_dy1_mag <= s1_dy1[DIFF_W-1] ? DY_W'(-s1_dy1) : DY_W'(s1_dy1);
      s2_dy2_mag <= s1_dy2[DIFF_W-1] ? DY_W'(-s1_dy2) : DY_W'(s1_dy2);
      s2_dy1_neg <= s1_dy1[DIFF_W-1];
      s2_dy2_neg <= s1_dy2[DIFF_W-1];
      s2_v3y     <= s1_v3y;

      s3_det     <= SUM_W'(s2_pdg)  - SUM_W'(s2_pef);
      s3_n1      <= SUM_W'(s2_pddx) + SUM_W'(s2_pedz);
      s3_n2      <= SUM_W'(s2_pfdx) + SUM_W'(s2_pgdz);
      s3_dy1_mag <= s2_dy1_mag;
      s3_dy2_mag <= s2_dy2_mag;
      s3_dy1_neg <= s2_dy1_neg;
      s3_dy2_neg <= s2_dy2_neg;
      s3_v3y     <= s2_v3y;

      out_data.det_mag  <= s3_det[SUM_W-1] ? SUM_W'(-s3_det) : SUM_W'(s3_det);
      out_data.det_neg  <= s3_det[SUM_W-1];
      out_data.det_zero <= (s3_det == '0);
      out_data.n1_mag   <= s3_n1[SUM_W-1] ? SUM_W'(-s3_n1) : SUM_W'(s3_n1);
      out_data.n1_neg   <= s3_n1[SUM_W-1];
      out_data.n2_mag   <= s3_n2[SUM_W-1] ? SUM_W'(-s3_n2) : SUM_W'(s3_n2);
      out_data.n2_neg   <= s3_n2[SUM_W-1];
      out_data.dy1_mag  <= s3_dy1_mag;
      out_data.dy1_neg  <= s3_dy1_neg;
      out_data.dy2_mag  <= s3_dy2_mag;
      out_data.dy2_neg  <= s3_dy2_neg;
      out_data.v3_y     <= s3_v3y;
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/bhi_numer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhi_numer
// Six stages: split products, recombine, sign, sum, magnitude and the
// quotient range check that seeds the divider.
// ----------------------------------------------------------------------------
module bhi_numer (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  bhi_pkg::front_t in_data,
  output logic            out_valid,
  output bhi_pkg::div_t   out_data
);
  import bhi_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;

  // per-stage copies of the determinant and v3 height
  logic [SUM_W-1:0]             dm5, dm6, dm7, dm8, dm9;
  logic                         dn5, dn6, dn7, dn8;
  logic                         dz5, dz6, dz7, dz8, dz9;
  logic signed [COORD_BITS-1:0] vy5, vy6, vy7, vy8, vy9;

  logic [LO_W+DY_W-1:0] s5_lo1, s5_lo2;
  logic [HI_W+DY_W-1:0] s5_hi1, s5_hi2;
  logic                 s5_neg1, s5_neg2, s6_neg1, s6_neg2;
  logic [PART_W-1:0]    s6_m1, s6_m2;
  logic signed [NUM_W-1:0] s7_t1, s7_t2, s8_num;
  logic [NUM_W-1:0]     s9_mag;
  logic                 s9_qneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of |n| * |dy|
      s5_lo1  <= in_data.n1_mag[LO_W-1:0] * in_data.dy1_mag;
      s5_hi1  <= in_data.n1_mag[SUM_W-1:LO_W] * in_data.dy1_mag;
      s5_lo2  <= in_data.n2_mag[LO_W-1:0] * in_data.dy2_mag;
      s5_hi2  <= in_data.n2_mag[SUM_W-1:LO_W] * in_data.dy2_mag;
      s5_neg1 <= in_data.n1_neg ^ in_data.dy1_neg;
      s5_neg2 <= in_data.n2_neg ^ in_data.dy2_neg;
      dm5 <= in_data.det_mag;
      dn5 <= in_data.det_neg;
      dz5 <= in_data.det_zero;
      vy5 <= in_data.v3_y;

      // recombine halves
      s6_m1   <= PART_W'(s5_lo1) + (PART_W'(s5_hi1) << LO_W);
      s6_m2   <= PART_W'(s5_lo2) + (PART_W'(s5_hi2) << LO_W);
      s6_neg1 <= s5_neg1;
      s6_neg2 <= s5_neg2;
      dm6 <= dm5;
      dn6 <= dn5;
      dz6 <= dz5;
      vy6 <= vy5;

      // apply signs
      s7_t1 <= s6_neg1 ? -$signed({2'b00, s6_m1}) : $signed({2'b00, s6_m1});
      s7_t2 <= s6_neg2 ? -$signed({2'b00, s6_m2}) : $signed({2'b00, s6_m2});
      dm7 <= dm6;
      dn7 <= dn6;
      dz7 <= dz6;
      vy7 <= vy6;

      // numerator
      s8_num <= s7_t1 + s7_t2;
      dm8 <= dm7;
      dn8 <= dn7;
      dz8 <= dz7;
      vy8 <= vy7;

      // magnitude and quotient sign
      s9_mag  <= s8_num[NUM_W-1] ? NUM_W'(-s8_num) : NUM_W'(s8_num);
      s9_qneg <= s8_num[NUM_W-1] ^ dn8;
      dm9 <= dm8;
      dz9 <= dz8;
      vy9 <= vy8;

      // range check and divider seed
      out_data.rem   <= {1'b0, s9_mag[NUM_W-1:QB]};
      out_data.low   <= s9_mag[QB-1:0];
      out_data.quo   <= '0;
      out_data.dmag  <= dm9;
      out_data.neg   <= s9_qneg;
      out_data.ovf   <= ((NUM_W + 1)'(s9_mag) >= {dm9, {QB{1'b0}}});
      out_data.degen <= dz9;
      out_data.v3_y  <= vy9;
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/bhi_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhi_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bhi_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  bhi_pkg::div_t in_data,
  output logic          out_valid,
  output bhi_pkg::div_t out_data
);
  import bhi_pkg::*;

  div_t      stg [QB];
  logic [QB-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    div_t           cur;
    div_t           nxt;
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign cur = in_data;
    end else begin : g_rest
      assign cur = stg[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial = {cur.rem, cur.low[QB-1]};
      ge    = (trial >= {1'b0, cur.dmag});
      diff  = trial - {1'b0, cur.dmag};
      nxt       = cur;
      nxt.rem   = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      nxt.low   = {cur.low[QB-2:0], 1'b0};
      nxt.quo   = {cur.quo[QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt;
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign out_data  = stg[QB-1];

endmodule
`default_nettype wire

FILE: hdl/bhi_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhi_outq
// Sign, saturation and degenerate handling, then a two-entry output queue
// that sets the pipeline advance.
// ----------------------------------------------------------------------------
module bhi_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bhi_pkg::div_t in_data,
  output logic          en,
  output logic          m_valid,
  input  logic          m_ready,
  output bhi_pkg::res_t m_data
);
  import bhi_pkg::*;

  logic signed [QB:0]   qs;
  logic signed [QB+1:0] hsum;
  logic                 big;
  res_t                 res_next;
  res_t                 fin;
  logic                 fin_valid;
  res_t                 ent0, ent1;
  logic [1:0]           count;
  logic                 push, pop;

  // final height
  always_comb begin
    qs   = in_data.neg ? -$signed({1'b0, in_data.quo}) : $signed({1'b0, in_data.quo});
    hsum = (QB + 2)'(qs) + (QB + 2)'(in_data.v3_y);
    big  = in_data.ovf || (in_data.quo > QUO_LIMIT);
    res_next.degenerate = in_data.degen;
    priority if (in_data.degen) begin
      res_next.height = '0;
    end else if (big) begin
      res_next.height = in_data.neg ? H_MIN : H_MAX;
    end else if (hsum > (QB + 2)'(H_MAX)) begin
      res_next.height = H_MAX;
    end else if (hsum < (QB + 2)'(H_MIN)) begin
      res_next.height = H_MIN;
    end else begin
      res_next.height = hsum[COORD_BITS-1:0];
    end
  end

  // pipeline advances while the queue has room
  assign en      = (count != 2'd2);
  assign push    = fin_valid && en;
  assign m_valid = (count != 2'd0);
  assign pop     = m_valid && m_ready;
  assign m_data  = ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= res_next;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          ent0 <= fin;
        end else begin
          ent1 <= fin;
        end
      end
      2'b01: begin
        ent0 <= ent1;
      end
      2'b11: begin
        ent0 <= fin;
      end
      default: begin
        ent0 <= ent0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the barycentric height interpolation core.
// ----------------------------------------------------------------------------
// A queue of triangle/query beats, directed corner cases first and then
// random shapes, feeds a clocked driver that sends in bursts with gaps. A
// clocked monitor takes result beats under a stall pattern with one long
// hold-off, and checks height and the degenerate flag against an exact
// wide-integer computation of the interpolated height.
// ----------------------------------------------------------------------------
module tb;

  import bhi_pkg::*;

  // one input beat: three vertices and the query point
  typedef struct {
    logic signed [31:0] v1_x, v1_y, v1_z;
    logic signed [31:0] v2_x, v2_y, v2_z;
    logic signed [31:0] v3_x, v3_y, v3_z;
    logic signed [31:0] query_x, query_z;
  } facet_t;

  // one predicted result beat
  typedef struct {
    logic signed [31:0] height;
    logic               degenerate;
  } height_res_t;

  typedef enum {SHAPE_PLAIN, SHAPE_FULL, SHAPE_FLAT, SHAPE_STEEP, SHAPE_MIXED} shape_t;
  typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam int N_RANDOM     = 1100;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  facet_t      facet_backlog[$];
  height_res_t height_expect[$];
  facet_t      facet_on_bus;
  int          beats_in = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          seg_left = 0;
  rx_mode_t    seg_mode = RX_FLOW;

  barycentric_height_interp_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // exact interpolated height, all intermediates kept at 128 bits
  function automatic height_res_t interp_height(facet_t p);
    logic signed [127:0] x1, y1, z1, x2, y2, z2, x3, y3, z3, qx, qz;
    logic signed [127:0] d, e, f, g, dx, dz, dy1, dy2;
    logic signed [127:0] det, n1, n2, num, quo, h;
    height_res_t r;
    x1 = p.v1_x; y1 = p.v1_y; z1 = p.v1_z;
    x2 = p.v2_x; y2 = p.v2_y; z2 = p.v2_z;
    x3 = p.v3_x; y3 = p.v3_y; z3 = p.v3_z;
    qx = p.query_x; qz = p.query_z;
    d   = z2 - z3;
    e   = x3 - x2;
    f   = z3 - z1;
    g   = x1 - x3;
    dx  = qx - x3;
    dz  = qz - z3;
    dy1 = y1 - y3;
    dy2 = y2 - y3;
    det = d * g - e * f;
    if (det == 0) begin
      r.height     = '0;
      r.degenerate = 1'b1;
      return r;
    end
    n1  = d * dx + e * dz;
    n2  = f * dx + g * dz;
    num = n1 * dy1 + n2 * dy2;
    // signed division truncates toward zero
    quo = num / det;
    h   = quo + y3;
    if (h > 128'(CMAX)) h = 128'(CMAX);
    if (h < 128'(CMIN)) h = 128'(CMIN);
    r.height     = h[31:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic facet_t mk_facet(
    logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qz);
    facet_t p;
    p.v1_x = ax; p.v1_y = ay; p.v1_z = az;
    p.v2_x = bx; p.v2_y = by; p.v2_z = bz;
    p.v3_x = cx; p.v3_y = cy; p.v3_z = cz;
    p.query_x = qx; p.query_z = qz;
    return p;
  endfunction

  // random word scaled down by an arithmetic shift
  function automatic logic signed [31:0] rnd_scaled(int sh);
    logic signed [31:0] w;
    w = $urandom;
    return w >>> sh;
  endfunction

  // one random beat of the given shape
  function automatic facet_t rnd_facet(shape_t shape);
    facet_t p;
    int sh;
    logic signed [31:0] bx, bz, ux, uz, a1, a2, a3;
    case (shape)
      SHAPE_PLAIN: begin
        sh = $urandom_range(8, 20);
        p = mk_facet(rnd_scaled(sh), rnd_scaled($urandom_range(4, 16)), rnd_scaled(sh),
                     rnd_scaled(sh), rnd_scaled($urandom_range(4, 16)), rnd_scaled(sh),
                     rnd_scaled(sh), rnd_scaled($urandom_range(4, 16)), rnd_scaled(sh),
                     rnd_scaled(sh), rnd_scaled(sh));
      end
      SHAPE_FULL: begin
        p = mk_facet($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      SHAPE_FLAT: begin
        // collinear projection, sometimes with a repeated vertex
        bx = rnd_scaled(4);  bz = rnd_scaled(4);
        ux = rnd_scaled(20); uz = rnd_scaled(20);
        a1 = rnd_scaled(24); a2 = rnd_scaled(24); a3 = rnd_scaled(24);
        if ($urandom_range(0, 3) == 0) a2 = a1;
        p = mk_facet(bx + a1 * ux, $urandom, bz + a1 * uz,
                     bx + a2 * ux, $urandom, bz + a2 * uz,
                     bx + a3 * ux, $urandom, bz + a3 * uz,
                     $urandom, $urandom);
      end
      SHAPE_STEEP: begin
        // tiny footprint, wild heights, far query: drives saturation
        p = mk_facet(rnd_scaled(27), $urandom, rnd_scaled(27),
                     rnd_scaled(27), $urandom, rnd_scaled(27),
                     rnd_scaled(27), $urandom, rnd_scaled(27),
                     rnd_scaled($urandom_range(0, 8)), rnd_scaled($urandom_range(0, 8)));
      end
      default: begin
        p = mk_facet(rnd_scaled($urandom_range(0, 31)), rnd_scaled($urandom_range(0, 31)),
                     rnd_scaled($urandom_range(0, 31)), rnd_scaled($urandom_range(0, 31)),
                     rnd_scaled($urandom_range(0, 31)), rnd_scaled($urandom_range(0, 31)),
                     rnd_scaled($urandom_range(0, 31)), rnd_scaled($urandom_range(0, 31)),
                     rnd_scaled($urandom_range(0, 31)), rnd_scaled($urandom_range(0, 31)),
                     rnd_scaled($urandom_range(0, 31)));
      end
    endcase
    return p;
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // sender: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        height_expect.push_back(interp_height(facet_on_bus));
        beats_in <= beats_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (facet_backlog.size() > 0) begin
          facet_on_bus = facet_backlog.pop_front();
          s_axis_tdata <= IN_W'({facet_on_bus.query_z, facet_on_bus.query_x,
                                 facet_on_bus.v3_z, facet_on_bus.v3_y, facet_on_bus.v3_x,
                                 facet_on_bus.v2_z, facet_on_bus.v2_y, facet_on_bus.v2_x,
                                 facet_on_bus.v1_z, facet_on_bus.v1_y, facet_on_bus.v1_x});
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: segments of stall modes, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (seg_mode)
          RX_FLOW:  m_axis_tready <= 1'b1;
          RX_LIGHT: m_axis_tready <= ($urandom_range(0, 9) < 7);
          RX_HEAVY: m_axis_tready <= ($urandom_range(0, 9) < 3);
          default:  m_axis_tready <= seg_left[2];
        endcase
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    height_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (height_expect.size() == 0) begin
        $error("result beat with no prediction pending: height %0d, degenerate %0d",
               $signed(m_axis_tdata[31:0]), m_axis_tuser[0]);
        mismatches++;
      end else begin
        want = height_expect.pop_front();
        if (m_axis_tdata[31:0] !== want.height) begin
          $error("height: expected %0d, got %0d", want.height, $signed(m_axis_tdata[31:0]));
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    shape_t shape;
    // unit right triangle, query inside, outside and on the vertices
    facet_backlog.push_back(mk_facet(0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE,
                                     ONE / 4, ONE / 4));
    facet_backlog.push_back(mk_facet(0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE,
                                     -3 * ONE, 5 * ONE));
    facet_backlog.push_back(mk_facet(0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE, 0, 0));
    facet_backlog.push_back(mk_facet(0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE, ONE, 0));
    facet_backlog.push_back(mk_facet(0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE, 0, ONE));
    // reversed winding gives a negative determinant
    facet_backlog.push_back(mk_facet(ONE, 2 * ONE, 0, 0, ONE, 0, 0, -3 * ONE, ONE,
                                     ONE / 3, ONE / 5));
    // degenerate: all zero, repeated vertex, collinear
    facet_backlog.push_back(mk_facet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    facet_backlog.push_back(mk_facet(ONE, 7, ONE, ONE, -9, ONE, 0, 5, 3 * ONE, ONE, ONE));
    facet_backlog.push_back(mk_facet(0, CMAX, 0, ONE, CMIN, ONE, 2 * ONE, 3, 2 * ONE,
                                     ONE, 0));
    // all extremes
    facet_backlog.push_back(mk_facet(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                     CMAX, CMAX));
    facet_backlog.push_back(mk_facet(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                     CMIN, CMIN));
    facet_backlog.push_back(mk_facet(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX,
                                     CMAX, CMAX));
    facet_backlog.push_back(mk_facet(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX,
                                     CMIN, CMIN));
    facet_backlog.push_back(mk_facet(CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN,
                                     0, 0));
    // tiny footprint with far query: positive and negative saturation
    facet_backlog.push_back(mk_facet(0, CMAX, 0, 1, CMIN, 0, 0, 0, 1, CMAX, CMAX));
    facet_backlog.push_back(mk_facet(0, CMAX, 0, 1, CMIN, 0, 0, 0, 1, CMIN, CMIN));
    facet_backlog.push_back(mk_facet(0, CMAX, 0, 1, CMAX, 0, 0, CMAX, 1, 5, 5));
    facet_backlog.push_back(mk_facet(0, CMIN, 0, 1, CMIN, 0, 0, CMIN, 1, -5, -5));
    // alternating bit patterns
    facet_backlog.push_back(mk_facet(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                                     32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                     32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                                     32'shAAAA_AAAA, 32'sh5555_5555));
    facet_backlog.push_back(mk_facet(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                                     32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                     32'sh5555_5555, 32'shAAAA_AAAA));

    // random part, mostly well-formed triangles
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      shape = SHAPE_PLAIN;
      else if (r < 55) shape = SHAPE_FULL;
      else if (r < 70) shape = SHAPE_FLAT;
      else if (r < 85) shape = SHAPE_STEEP;
      else             shape = SHAPE_MIXED;
      facet_backlog.push_back(rnd_facet(shape));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to be sent and every result to come back
    do @(posedge clk);
    while (facet_backlog.size() != 0 || s_axis_tvalid || height_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (height_expect.size() != 0) begin
      $error("%0d predicted results never arrived", height_expect.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
hdl/bhi_pkg.sv
hdl/bhi_front.sv
hdl/bhi_numer.sv
hdl/bhi_divider.sv
hdl/bhi_outq.sv
hdl/barycentric_height_interp_core.sv
verif/tb.sv
